/* rtl/core/hpq_pkg.sv */
package hpq_pkg;

   // default sizes
   localparam int CAPACITY_DEFAULT  = 64;
   localparam int KEY_WIDTH_DEFAULT = 32;

   // fixed widths of the item fields
   localparam int KEY_PORT_W   = 32;
   localparam int COUNT_PORT_W = 7;
   localparam int FUNC_W       = 2;

   // request operation codes
   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_CLEAR  = 2'd2
   } func_type;

   // key store read address source
   typedef enum logic [1:0] {
      RD_PARENT = 2'd0,
      RD_LAST   = 2'd1,
      RD_LEFT   = 2'd2,
      RD_RIGHT  = 2'd3
   } rd_sel_type;

   // key store write data source
   typedef enum logic [1:0] {
      WR_KEY   = 2'd0,
      WR_RDATA = 2'd1,
      WR_CHILD = 2'd2
   } wr_sel_type;

   // controller states
   typedef enum logic [3:0] {
      S_IDLE,
      S_UP_CHECK,
      S_UP_CMP,
      S_DN_LAST,
      S_DN_START,
      S_DN_CHECK,
      S_DN_LEFT,
      S_DN_RIGHT,
      S_DN_CMP,
      S_FINISH
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic       start_insert;
      logic       start_remove;
      logic       clear_heap;
      logic       ok_load;
      logic       ok_value;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       load_key_rdata;
      logic       pos_to_root;
      logic       pos_to_parent;
      logic       pos_to_big;
      logic       load_left;
      logic       take_right;
      logic       rsp_load;
   } hpq_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic full;
      logic count_zero;
      logic pos_zero;
      logic left_ok;
      logic right_ok;
      logic key_gt_rdata;
      logic right_gt_child;
      logic key_ge_child;
      logic rsp_free;
   } hpq_status_type;

endpackage

/* rtl/core/hpq_ctrl.sv */
module hpq_ctrl import hpq_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [FUNC_W-1:0]   req_func,
   input  hpq_status_type      status,
   output hpq_cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;
   func_type  func;
   logic      accept;

   assign func      = func_type'(req_func);
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (func)
                  FUNC_INSERT: state_in = status.full ? S_FINISH : S_UP_CHECK;
                  FUNC_REMOVE: state_in = status.count_zero ? S_FINISH : S_DN_LAST;
                  default:     state_in = S_FINISH;
               endcase
            end
         end
         S_UP_CHECK: state_in = status.pos_zero ? S_FINISH : S_UP_CMP;
         S_UP_CMP:   state_in = status.key_gt_rdata ? S_UP_CHECK : S_FINISH;
         S_DN_LAST:  state_in = S_DN_START;
         S_DN_START: state_in = status.count_zero ? S_FINISH : S_DN_CHECK;
         S_DN_CHECK: state_in = status.left_ok ? S_DN_LEFT : S_FINISH;
         S_DN_LEFT:  state_in = status.right_ok ? S_DN_RIGHT : S_DN_CMP;
         S_DN_RIGHT: state_in = S_DN_CMP;
         S_DN_CMP:   state_in = status.key_ge_child ? S_FINISH : S_DN_CHECK;
         S_FINISH:   state_in = status.rsp_free ? S_IDLE : S_FINISH;
         default:    state_in = S_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.ok_load = 1'b1;
               unique case (func)
                  FUNC_INSERT: begin
                     cmd.start_insert = !status.full;
                     cmd.ok_value     = !status.full;
                  end
                  FUNC_REMOVE: begin
                     cmd.start_remove = !status.count_zero;
                     cmd.ok_value     = !status.count_zero;
                  end
                  FUNC_CLEAR: begin
                     cmd.clear_heap = 1'b1;
                     cmd.ok_value   = 1'b1;
                  end
                  default: cmd.ok_value = 1'b0;
               endcase
            end
         end
         // hole at root: place key, else fetch parent
         S_UP_CHECK: begin
            if (status.pos_zero) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WR_KEY;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_PARENT;
            end
         end
         // move parent down or settle key
         S_UP_CMP: begin
            cmd.wr_en = 1'b1;
            if (status.key_gt_rdata) begin
               cmd.wr_sel        = WR_RDATA;
               cmd.pos_to_parent = 1'b1;
            end else begin
               cmd.wr_sel = WR_KEY;
            end
         end
         S_DN_LAST: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_LAST;
         end
         S_DN_START: begin
            cmd.load_key_rdata = 1'b1;
            cmd.pos_to_root    = 1'b1;
         end
         S_DN_CHECK: begin
            if (status.left_ok) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_LEFT;
            end else begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WR_KEY;
            end
         end
         S_DN_LEFT: begin
            cmd.load_left = 1'b1;
            if (status.right_ok) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_RIGHT;
            end
         end
         S_DN_RIGHT: cmd.take_right = status.right_gt_child;
         // move larger child up or settle key
         S_DN_CMP: begin
            cmd.wr_en = 1'b1;
            if (status.key_ge_child) begin
               cmd.wr_sel = WR_KEY;
            end else begin
               cmd.wr_sel     = WR_CHILD;
               cmd.pos_to_big = 1'b1;
            end
         end
         S_FINISH: cmd.rsp_load = status.rsp_free;
         default: cmd = '0;
      endcase
   end

endmodule

/* rtl/core/hpq_datapath.sv */
module hpq_datapath import hpq_pkg::*; #(
   parameter int CAPACITY  = CAPACITY_DEFAULT,
   parameter int KEY_WIDTH = KEY_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  hpq_cmd_type                    cmd,
   output hpq_status_type                 status,
   input  logic signed [KEY_PORT_W-1:0]   req_key_in,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_accepted,
   output logic signed [KEY_PORT_W-1:0]   rsp_top_key,
   output logic                           rsp_is_empty,
   output logic [COUNT_PORT_W-1:0]        rsp_entry_count
);

   localparam int IDX_W   = $clog2(CAPACITY);
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int CHILD_W = IDX_W + 2;
   localparam int WIDE_W  = KEY_WIDTH + KEY_PORT_W;
   localparam int CWIDE_W = CNT_W + COUNT_PORT_W;

   logic signed [KEY_WIDTH-1:0] key_store_ff [CAPACITY];

   logic [CNT_W-1:0]            count_ff, count_in;
   logic [IDX_W-1:0]            pos_ff, pos_in;
   logic [IDX_W-1:0]            big_ff, big_in;
   logic signed [KEY_WIDTH-1:0] key_ff, key_in;
   logic signed [KEY_WIDTH-1:0] child_ff, child_in;
   logic signed [KEY_WIDTH-1:0] rdata_ff;
   logic signed [KEY_WIDTH-1:0] top_ff, top_in;
   logic                        ok_ff, ok_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_accepted_ff;
   logic signed [KEY_PORT_W-1:0] rsp_top_key_ff;
   logic                        rsp_is_empty_ff;
   logic [COUNT_PORT_W-1:0]     rsp_entry_count_ff;

   logic [IDX_W-1:0]            parent;
   logic [CHILD_W-1:0]          left, right, count_ext;
   logic [IDX_W-1:0]            raddr;
   logic signed [KEY_WIDTH-1:0] wdata;
   logic [WIDE_W-1:0]           key_req_wide;
   logic signed [WIDE_W-1:0]    top_wide;
   logic [CWIDE_W-1:0]          count_wide;

   // tree index arithmetic
   assign parent    = IDX_W'((pos_ff - IDX_W'(1)) >> 1);
   assign left      = {1'b0, pos_ff, 1'b1};
   assign right     = left + CHILD_W'(1);
   assign count_ext = CHILD_W'(count_ff);

   // incoming key: low bits taken, sign-extended above the port width
   assign key_req_wide = WIDE_W'(req_key_in);

   // status toward controller
   assign status.full           = (count_ff == CNT_W'(CAPACITY));
   assign status.count_zero     = (count_ff == '0);
   assign status.pos_zero       = (pos_ff == '0);
   assign status.left_ok        = (left < count_ext);
   assign status.right_ok       = (right < count_ext);
   assign status.key_gt_rdata   = (key_ff > rdata_ff);
   assign status.right_gt_child = (rdata_ff > child_ff);
   assign status.key_ge_child   = (key_ff >= child_ff);
   assign status.rsp_free       = !rsp_valid_ff || !rsp_stall;

   // read address select
   always_comb begin
      case (cmd.rd_sel)
         RD_PARENT: raddr = parent;
         RD_LAST:   raddr = count_ff[IDX_W-1:0];
         RD_LEFT:   raddr = left[IDX_W-1:0];
         RD_RIGHT:  raddr = right[IDX_W-1:0];
         default:   raddr = parent;
      endcase
   end

   // write data select
   always_comb begin
      case (cmd.wr_sel)
         WR_KEY:   wdata = key_ff;
         WR_RDATA: wdata = rdata_ff;
         WR_CHILD: wdata = child_ff;
         default:  wdata = key_ff;
      endcase
   end

   // key store, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         key_store_ff[pos_ff] <= wdata;
      end
      if (cmd.rd_en) begin
         rdata_ff <= key_store_ff[raddr];
      end
   end

   // next values of working registers
   always_comb begin
      count_in = count_ff;
      pos_in   = pos_ff;
      big_in   = big_ff;
      key_in   = key_ff;
      child_in = child_ff;
      top_in   = top_ff;
      ok_in    = cmd.ok_load ? cmd.ok_value : ok_ff;
      if (cmd.start_insert) begin
         key_in   = key_req_wide[KEY_WIDTH-1:0];
         pos_in   = count_ff[IDX_W-1:0];
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.start_remove) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (cmd.clear_heap) begin
         count_in = '0;
      end
      if (cmd.load_key_rdata) begin
         key_in = rdata_ff;
      end
      if (cmd.pos_to_root) begin
         pos_in = '0;
      end else if (cmd.pos_to_parent) begin
         pos_in = parent;
      end else if (cmd.pos_to_big) begin
         pos_in = big_ff;
      end
      if (cmd.load_left) begin
         child_in = rdata_ff;
         big_in   = left[IDX_W-1:0];
      end else if (cmd.take_right) begin
         child_in = rdata_ff;
         big_in   = right[IDX_W-1:0];
      end
      // root copy follows every write to the root entry
      if (cmd.wr_en && (pos_ff == '0)) begin
         top_in = wdata;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      pos_ff   <= pos_in;
      big_ff   <= big_in;
      key_ff   <= key_in;
      child_ff <= child_in;
      top_ff   <= top_in;
      ok_ff    <= ok_in;
   end

   // result formatting, key bits zero-filled above the key width
   assign top_wide   = WIDE_W'($unsigned(top_ff));
   assign count_wide = CWIDE_W'(count_ff);

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.rsp_load) begin
         rsp_accepted_ff    <= ok_ff;
         rsp_top_key_ff     <= (count_ff == '0) ? '0 : top_wide[KEY_PORT_W-1:0];
         rsp_is_empty_ff    <= (count_ff == '0);
         rsp_entry_count_ff <= count_wide[COUNT_PORT_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = rsp_accepted_ff;
   assign rsp_top_key     = rsp_top_key_ff;
   assign rsp_is_empty    = rsp_is_empty_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

endmodule

/* rtl/core/binary_max_heap_queue_unit.sv */
// binary max-heap priority queue, one request item in, one result item out
// insert: the new key enters at the last free entry and climbs toward the root while greater than its parent
// remove: the last key moves to the root and sinks while smaller than its larger child,
//   reading only the left child at a level with a single child; removing the sole key empties the heap
// clear and refused requests go straight to the result; the result is registered before the output
// synchronous active-high reset empties the heap at once; key store contents are not cleared
module binary_max_heap_queue_unit import hpq_pkg::*; #(
   parameter int CAPACITY  = CAPACITY_DEFAULT,
   parameter int KEY_WIDTH = KEY_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [FUNC_W-1:0]             req_func,
   input  logic signed [KEY_PORT_W-1:0]  req_key_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_accepted,
   output logic signed [KEY_PORT_W-1:0]  rsp_top_key,
   output logic                          rsp_is_empty,
   output logic [COUNT_PORT_W-1:0]       rsp_entry_count
);

   hpq_cmd_type    cmd;
   hpq_status_type status;

   // sequencer
   hpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_func  (req_func),
      .status    (status),
      .cmd       (cmd)
   );

   // key store, index arithmetic and result register
   hpq_datapath #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_key_in      (req_key_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_accepted    (rsp_accepted),
      .rsp_top_key     (rsp_top_key),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule
